/* rtl/ranged_string_id_incrementer_assert.svh */
// Assertion macros for the ranged string ID incrementer.
// Users must have clk and rst_n in scope where the macros are used.
`ifndef RANGED_STRING_ID_INCREMENTER_ASSERT_SVH
`define RANGED_STRING_ID_INCREMENTER_ASSERT_SVH

// Checked on every rising edge once reset has been released.
`define RSID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RSID_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsid_pkg.sv */
// Shared types and constants for the ranged string ID incrementer.
// No dependencies; the interfaces and the top level use this package.
package rsid_pkg;

    // Field widths of the channels.
    localparam int VALUE_W  = 64;
    localparam int LEN_W    = 4;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int TAG_W    = 2;

    // Default sizes.
    localparam int ID_BYTES_DEF    = 8;
    localparam int RANGE_SLOTS_DEF = 3;
    localparam int RANGE_MAX       = 3;

    // Register reset values.
    localparam logic [7:0] RANGE_LOW_RST  [RANGE_MAX] = '{8'd48, 8'd65, 8'd97};
    localparam logic [7:0] RANGE_HIGH_RST [RANGE_MAX] = '{8'd57, 8'd90, 8'd122};
    localparam logic [1:0] RANGES_RST = 2'd3;
    localparam logic [3:0] LIMIT_RST  = 4'd8;

    // Register indexes that are not range bounds.
    localparam logic [CFG_IDX_W-1:0] CFG_RANGES_IN_USE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 3'd7;

    // Action codes.
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_REJECTED  = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_RUN    = 3'b010,
        S_FINISH = 3'b100
    } seq_state_t;

endpackage

/* rtl/rsid_if.sv */
// Channel interfaces of the ranged string ID incrementer: request, response
// and register write. Depends on rsid_pkg for the field widths.
interface rsid_req_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [rsid_pkg::VALUE_W-1:0]   load_value;
    logic [rsid_pkg::LEN_W-1:0]     load_length;

    modport source (output valid, action, load_value, load_length, input ready);
    modport sink   (input valid, action, load_value, load_length, output ready);
endinterface

interface rsid_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [rsid_pkg::VALUE_W-1:0]   id_value;
    logic [rsid_pkg::LEN_W-1:0]     id_length;
    logic [rsid_pkg::STAT_W-1:0]    status;

    modport source (output valid, id_value, id_length, status, input ready);
    modport sink   (input valid, id_value, id_length, status, output ready);
endinterface

interface rsid_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rsid_pkg::CFG_IDX_W-1:0] index;
    logic [rsid_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ranged_string_id_incrementer.sv */
// Ranged string ID incrementer: byte-serial odometer over character ranges.
// From a request beat the sequencer runs through S_RUN, one step per byte, then
// S_FINISH, where the response beat is registered once the response slot is free;
// one request is worked on at a time, so a new request is taken only in S_IDLE.
// Reset: the ID is empty, all bytes and tags zero, registers at defaults.
`include "ranged_string_id_incrementer_assert.svh"

module ranged_string_id_incrementer #(
    parameter int ID_BYTES    = rsid_pkg::ID_BYTES_DEF,
    parameter int RANGE_SLOTS = rsid_pkg::RANGE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rsid_req_if.sink    req,
    rsid_rsp_if.source  rsp,
    rsid_cfg_if.sink    cfg
);
    import rsid_pkg::*;

    localparam int CNT_W = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;

    // Configuration registers.
    logic [7:0]         low_reg  [RANGE_SLOTS];
    logic [7:0]         high_reg [RANGE_SLOTS];
    logic [1:0]         ranges_reg;
    logic [LEN_W-1:0]   limit_reg;

    // Committed ID, last character in byte 0.
    logic [ID_BYTES-1:0][7:0]       id_reg;
    logic [ID_BYTES-1:0][TAG_W-1:0] tag_reg;
    logic [LEN_W-1:0]               len_reg;

    // Working shift registers and sequencer.
    seq_state_t                     state_reg, state_next;
    logic [ID_BYTES-1:0][7:0]       work_bytes_reg, work_bytes_next;
    logic [ID_BYTES-1:0][TAG_W-1:0] work_tags_reg, work_tags_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           op_reg;
    logic [LEN_W-1:0]               ld_len_reg;
    logic                           fail_reg, fail_next;
    logic                           carry_reg, carry_next;
    logic                           grow_reg, grow_next;

    // Response slot.
    logic       out_valid_reg;
    status_t    status_reg;

    logic [1:0]         n_act;
    logic [LEN_W-1:0]   eff_limit;
    logic [LEN_W-1:0]   pos;
    logic [LEN_W-1:0]   cur_len;
    logic               in_len;
    logic [7:0]         cur_b, new_b;
    logic [TAG_W-1:0]   cur_t, new_t, load_tag;
    logic [7:0]         hi_sel, low_nxt;
    logic [2:0]         nxt_t;
    logic [8:0]         inc;
    logic               found;
    logic               out_free;
    logic               finish;
    logic               commit;
    status_t            status_next;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid     = out_valid_reg;
    assign rsp.id_value  = VALUE_W'(id_reg);
    assign rsp.id_length = len_reg;
    assign rsp.status    = status_reg;

    // Active range count and effective length limit.
    always_comb
    begin
        if (ranges_reg == 2'd0)
            n_act = 2'd1;
        else if (ranges_reg > 2'(RANGE_SLOTS))
            n_act = 2'(RANGE_SLOTS);
        else
            n_act = ranges_reg;
        eff_limit = (limit_reg > LEN_W'(ID_BYTES)) ? LEN_W'(ID_BYTES) : limit_reg;
    end

    // Byte step unit: one byte of the working register per cycle.
    always_comb
    begin
        cur_b   = work_bytes_reg[0];
        cur_t   = work_tags_reg[0];
        pos     = LEN_W'(cnt_reg);
        cur_len = (op_reg == ACT_LOAD) ? ld_len_reg : len_reg;
        in_len  = (pos < cur_len);
        nxt_t   = {1'b0, cur_t} + 3'd1;
        inc     = {1'b0, cur_b} + 9'd1;

        hi_sel  = high_reg[0];
        low_nxt = low_reg[0];
        for (int k = 0; k < RANGE_SLOTS; k++)
        begin
            if (cur_t == TAG_W'(k))
                hi_sel = high_reg[k];
            if (nxt_t == 3'(k))
                low_nxt = low_reg[k];
        end

        // Lowest active range that holds the byte.
        found    = 1'b0;
        load_tag = '0;
        for (int k = RANGE_SLOTS - 1; k >= 0; k--)
        begin
            if ((2'(k) < n_act) && (cur_b >= low_reg[k]) && (cur_b <= high_reg[k]))
            begin
                found    = 1'b1;
                load_tag = TAG_W'(k);
            end
        end

        new_b      = cur_b;
        new_t      = cur_t;
        fail_next  = fail_reg;
        carry_next = carry_reg;
        grow_next  = grow_reg;

        if (op_reg == ACT_LOAD)
        begin
            if (in_len)
            begin
                new_t     = load_tag;
                fail_next = fail_reg | ~found;
            end
            else
            begin
                new_b = '0;
                new_t = '0;
            end
        end
        else if (in_len && carry_reg)
        begin
            if (inc <= {1'b0, hi_sel})
            begin
                new_b      = inc[7:0];
                carry_next = 1'b0;
            end
            else if (nxt_t < {1'b0, n_act})
            begin
                new_b      = low_nxt;
                new_t      = nxt_t[TAG_W-1:0];
                carry_next = 1'b0;
            end
            else
            begin
                new_b = low_reg[0];
                new_t = '0;
            end
        end
        else if (carry_reg && (pos == len_reg) && (len_reg != '0)
                 && (len_reg < eff_limit))
        begin
            // Carry out of the first character: the ID grows by one byte.
            new_b     = low_reg[0];
            new_t     = '0;
            grow_next = 1'b1;
        end

        work_bytes_next = work_bytes_reg >> 8;
        work_bytes_next[ID_BYTES-1] = new_b;
        work_tags_next = work_tags_reg >> TAG_W;
        work_tags_next[ID_BYTES-1] = new_t;
    end

    // Outcome of a finished pass.
    always_comb
    begin
        out_free = ~out_valid_reg | rsp.ready;
        finish   = (state_reg == S_FINISH) && out_free;
        commit   = 1'b0;
        if (op_reg == ACT_LOAD)
        begin
            if (fail_reg || (ld_len_reg > eff_limit))
                status_next = STAT_REJECTED;
            else
            begin
                status_next = STAT_OK;
                commit      = 1'b1;
            end
        end
        else if (len_reg == '0)
            status_next = STAT_EMPTY;
        else if (carry_reg && !grow_reg)
            status_next = STAT_EXHAUSTED;
        else
        begin
            status_next = STAT_OK;
            commit      = 1'b1;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cnt_reg == CNT_W'(ID_BYTES - 1))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RUN)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers: loaded on a request beat, shifted during the pass.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= req.action;
            ld_len_reg <= req.load_length;
            fail_reg   <= 1'b0;
            carry_reg  <= 1'b1;
            grow_reg   <= 1'b0;
            if (req.action == ACT_LOAD)
            begin
                work_bytes_reg <= req.load_value[ID_BYTES*8-1:0];
                work_tags_reg  <= '0;
            end
            else
            begin
                work_bytes_reg <= id_reg;
                work_tags_reg  <= tag_reg;
            end
        end
        else if (state_reg == S_RUN)
        begin
            work_bytes_reg <= work_bytes_next;
            work_tags_reg  <= work_tags_next;
            fail_reg       <= fail_next;
            carry_reg      <= carry_next;
            grow_reg       <= grow_next;
        end
    end

    // Committed ID.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= '0;
            tag_reg <= '0;
            len_reg <= '0;
        end
        else if (finish && commit)
        begin
            id_reg  <= work_bytes_reg;
            tag_reg <= work_tags_reg;
            if (op_reg == ACT_LOAD)
                len_reg <= ld_len_reg;
            else
                len_reg <= len_reg + LEN_W'(grow_reg);
        end
    end

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RANGE_SLOTS; k++)
            begin
                low_reg[k]  <= RANGE_LOW_RST[k];
                high_reg[k] <= RANGE_HIGH_RST[k];
            end
            ranges_reg <= RANGES_RST;
            limit_reg  <= LIMIT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            for (int k = 0; k < RANGE_SLOTS; k++)
            begin
                if (cfg.index == CFG_IDX_W'(2 * k))
                    low_reg[k] <= cfg.data;
                if (cfg.index == CFG_IDX_W'(2 * k + 1))
                    high_reg[k] <= cfg.data;
            end
            if (cfg.index == CFG_RANGES_IN_USE)
                ranges_reg <= cfg.data[1:0];
            if (cfg.index == CFG_LENGTH_LIMIT)
                limit_reg <= cfg.data[LEN_W-1:0];
        end
    end

    // The stored length never exceeds the byte store.
    `RSID_ASSERT(a_len_bound, len_reg <= LEN_W'(ID_BYTES), "ID length beyond store")
    // The committed ID only changes when a pass finishes.
    `RSID_ASSERT(a_id_hold, state_reg != S_FINISH |=> $stable(id_reg) && $stable(len_reg),
                 "ID changed outside finish")
    // A request beat starts a pass.
    `RSID_ASSERT(a_start, req.valid && req.ready |=> state_reg == S_RUN, "pass did not start")
    // A pass ends after one step per byte.
    `RSID_ASSERT(a_pass_len, state_reg == S_RUN && cnt_reg == CNT_W'(ID_BYTES - 1)
                 |=> state_reg == S_FINISH, "pass length wrong")

endmodule

/* verif/tb_ranged_string_id_incrementer.sv */
`timescale 1ns / 100ps
// Testbench for the ranged string ID incrementer. Load and advance beats run through
// a behavioural odometer model and each response beat is checked against it.
// Depends on rsid_pkg, the rsid_*_if interfaces and the ranged_string_id_incrementer top.
module tb_ranged_string_id_incrementer;
    import rsid_pkg::*;

    localparam int ID_BYTES    = ID_BYTES_DEF;
    localparam int RANGE_SLOTS = RANGE_SLOTS_DEF;
    localparam int CFG_REGS    = 8;
    localparam int NUM_SETS    = 9;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        logic               action;
        logic [VALUE_W-1:0] load_value;
        logic [LEN_W-1:0]   load_length;
    } id_request_t;

    typedef struct packed {
        logic [VALUE_W-1:0] id_value;
        logic [LEN_W-1:0]   id_length;
        status_t            status;
    } id_result_t;

    // Register settings, one row per phase, columns in register order: range 0 low
    // and high, range 1 low and high, range 2 low and high, ranges in use, length limit.
    // Row 0 is the short directed phase with one full-byte range.
    localparam logic [7:0] CFG_SETS [NUM_SETS][CFG_REGS] = '{
        '{8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd1, 8'd2},
        '{8'd48,  8'd57,  8'd65,  8'd90,  8'd97,  8'd122, 8'd3, 8'd8},
        '{8'd0,   8'd1,   8'd5,   8'd5,   8'd254, 8'd255, 8'd3, 8'd3},
        '{8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd1, 8'd8},
        '{8'd97,  8'd99,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 8'd0},
        '{8'd10,  8'd12,  8'd200, 8'd100, 8'd40,  8'd41,  8'd2, 8'd15},
        '{8'd30,  8'd40,  8'd35,  8'd50,  8'd0,   8'd255, 8'd3, 8'd1},
        '{8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd3, 8'd4},
        '{8'd0,   8'd0,   8'd255, 8'd255, 8'd128, 8'd128, 8'd3, 8'd8}
    };
    localparam int SET_ITEMS [NUM_SETS] = '{0, 300, 260, 260, 200, 260, 260, 60, 200};
    localparam int SEND_IDLE [NUM_SETS] = '{22, 22, 22, 22, 56, 56, 0, 0, 0};
    localparam int RECV_IDLE [NUM_SETS] = '{56, 56, 56, 56, 22, 22, 0, 0, 0};

    // Clock, reset and the values driven onto the channels.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    id_request_t          req_beat  = '0;
    logic                 rsp_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // Model copy of the registers and of the current ID.
    logic [7:0]  range_lo [RANGE_MAX] = RANGE_LOW_RST;
    logic [7:0]  range_hi [RANGE_MAX] = RANGE_HIGH_RST;
    logic [1:0]  ranges_set = RANGES_RST;
    logic [3:0]  limit_set  = LIMIT_RST;
    logic [7:0]  held_byte [ID_BYTES] = '{default: 8'd0};
    logic [1:0]  held_tag [ID_BYTES]  = '{default: 2'd0};
    int unsigned held_len = 0;

    id_request_t requests_to_send [$];
    id_result_t  ids_due [$];
    int          send_idle_pct = SEND_IDLE[0];
    int          rcv_idle_pct  = RECV_IDLE[0];
    int          fail_count    = 0;
    int          results_seen  = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    rsid_req_if req ();
    rsid_rsp_if rsp ();
    rsid_cfg_if cfg ();

    assign req.valid       = req_valid;
    assign req.action      = req_beat.action;
    assign req.load_value  = req_beat.load_value;
    assign req.load_length = req_beat.load_length;
    assign rsp.ready       = rsp_ready;
    assign cfg.valid       = cfg_valid;
    assign cfg.index       = cfg_index;
    assign cfg.data        = cfg_data;

    ranged_string_id_incrementer #(
        .ID_BYTES    (ID_BYTES),
        .RANGE_SLOTS (RANGE_SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    // Ranges in use: zero counts as one, anything above the slot count is clipped.
    function automatic int unsigned active_ranges();
        if (ranges_set == 2'd0)
            return 1;
        if (ranges_set > RANGE_SLOTS)
            return RANGE_SLOTS;
        return 32'(ranges_set);
    endfunction

    function automatic int unsigned length_cap();
        return (limit_set > ID_BYTES) ? ID_BYTES : limit_set;
    endfunction

    // Applies one request to the model ID and returns the response it should give.
    function automatic id_result_t apply_request(input id_request_t rq);
        logic [7:0]  nb [ID_BYTES];
        logic [1:0]  nr [ID_BYTES];
        logic [7:0]  ch;
        int unsigned n, len, c, r, j;
        bit          found, settled;
        id_result_t  res;
        n = active_ranges();
        nb = held_byte;
        nr = held_tag;
        res = '0;
        res.status = STAT_OK;
        if (rq.action == ACT_LOAD) begin
            len = 32'(rq.load_length);
            if (len > length_cap())
                res.status = STAT_REJECTED;
            for (int i = 0; i < len && res.status == STAT_OK; i++) begin
                ch = rq.load_value[8 * (len - 1 - i) +: 8];
                found = 1'b0;
                // Walk downwards so that the lowest-numbered matching range wins.
                for (int k = n - 1; k >= 0; k--) begin
                    if (ch >= range_lo[k] && ch <= range_hi[k]) begin
                        nr[i] = 2'(k);
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.status = STAT_REJECTED;
                nb[i] = ch;
            end
            if (res.status == STAT_OK) begin
                for (int i = 0; i < ID_BYTES; i++) begin
                    held_byte[i] = (i < len) ? nb[i] : 8'd0;
                    held_tag[i]  = (i < len) ? nr[i] : 2'd0;
                end
                held_len = len;
            end
        end else if (held_len == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            settled = 1'b0;
            len = held_len;
            // Carry walk from the last character towards the first.
            for (int p = held_len; p > 0 && !settled; p--) begin
                j = p - 1;
                r = nr[j] % RANGE_SLOTS;
                c = nb[j] + 1;
                if (c <= range_hi[r]) begin
                    nb[j] = 8'(c);
                    settled = 1'b1;
                end else if (r + 1 < n) begin
                    nr[j] = 2'(r + 1);
                    nb[j] = range_lo[r + 1];
                    settled = 1'b1;
                end else begin
                    nb[j] = range_lo[0];
                    nr[j] = 2'd0;
                end
            end
            if (!settled && len >= length_cap()) begin
                res.status = STAT_EXHAUSTED;
            end else begin
                // A carry out of the first character grows the ID at range 0's low end.
                if (!settled) begin
                    len++;
                    for (int i = 0; i < len; i++) begin
                        nb[i] = range_lo[0];
                        nr[i] = 2'd0;
                    end
                end
                held_byte = nb;
                held_tag  = nr;
                held_len  = len;
            end
        end
        for (int i = 0; i < held_len; i++)
            res.id_value = {res.id_value[VALUE_W-9:0], held_byte[i]};
        res.id_length = held_len[LEN_W-1:0];
        return res;
    endfunction

    function automatic void queue_load(input logic [VALUE_W-1:0] word, input int unsigned len);
        id_request_t rq;
        rq.action      = ACT_LOAD;
        rq.load_value  = word;
        rq.load_length = len[LEN_W-1:0];
        requests_to_send.push_back(rq);
    endfunction

    function automatic void queue_advance();
        id_request_t rq;
        rq.action      = ACT_ADVANCE;
        rq.load_value  = {$urandom, $urandom};
        rq.load_length = LEN_W'($urandom);
        requests_to_send.push_back(rq);
    endfunction

    task automatic wait_until_drained();
        while (requests_to_send.size() != 0 || req_valid || ids_due.size() != 0)
            @(posedge clk);
    endtask

    // Writes all eight registers back to back, keeping valid high between beats.
    task automatic write_setting(input int s);
        for (int r = 0; r < CFG_REGS; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= CFG_SETS[s][r];
            do
                @(posedge clk);
            while (!cfg.ready);
            if (r == CFG_RANGES_IN_USE)
                ranges_set = CFG_SETS[s][r][1:0];
            else if (r == CFG_LENGTH_LIMIT)
                limit_set = CFG_SETS[s][r][3:0];
            else if (r[0])
                range_hi[r >> 1] = CFG_SETS[s][r];
            else
                range_lo[r >> 1] = CFG_SETS[s][r];
        end
        cfg_valid <= 1'b0;
    endtask

    // Request driver: the model is stepped on every accepted beat.
    always @(posedge clk or negedge rst_n) begin : request_driver
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && req.ready)
                ids_due.push_back(apply_request(req_beat));
            if (!req_valid || req.ready) begin
                if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_beat  <= requests_to_send.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each beat and throttles ready, with a few long hold-offs.
    always @(posedge clk or negedge rst_n) begin : result_monitor
        id_result_t want;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp_ready) begin
                results_seen++;
                if (results_seen % 700 == 150)
                    hold_left = HOLD_CYCLES;
                if (ids_due.size() == 0) begin
                    $display("%0t: response beat with nothing expected: value %h length %0d status %0d",
                             $time, rsp.id_value, rsp.id_length, rsp.status);
                    fail_count++;
                end else begin
                    want = ids_due.pop_front();
                    if (rsp.id_value !== want.id_value) begin
                        $display("%0t: id_value expected %h, got %h",
                                 $time, want.id_value, rsp.id_value);
                        fail_count++;
                    end
                    if (rsp.id_length !== want.id_length) begin
                        $display("%0t: id_length expected %0d, got %0d",
                                 $time, want.id_length, rsp.id_length);
                        fail_count++;
                    end
                    if (rsp.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (req_valid && req.ready) || (rsp.valid && rsp_ready)
                || (cfg_valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned        roll, len, k;
        logic [VALUE_W-1:0] word;
        logic [7:0]         ch;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at the reset ranges: digits, capitals, lower case, up to eight bytes.
        queue_advance();                              // empty ID
        queue_load(64'h0, 0);                         // empty load is accepted
        queue_advance();
        queue_load(64'h7A7A_7A7A_7A7A_7A7A, 8);
        queue_advance();                              // carry out at the limit
        queue_load(64'h3030_3030_3030_3030, 8);
        queue_advance();
        queue_load(64'hFFFF_FFFF_FFFF_FF39, 1);       // bytes above the length ignored
        queue_advance();                              // moves on to the next range
        queue_load(64'h5A, 1);
        queue_advance();
        queue_load(64'h7A7A, 2);
        queue_advance();                              // grows by one byte
        queue_load(64'h397A, 2);
        queue_advance();                              // wrap with a carry into the next byte
        queue_load(64'h40, 1);                        // byte between ranges
        queue_load(64'h0, 1);
        queue_load(64'hFFFF_FFFF_FFFF_FFFF, 8);
        queue_load(64'h30_4030, 3);                   // one bad byte in the middle
        wait_until_drained();

        // One range spanning the whole byte and a limit of two: 255 must overflow.
        write_setting(0);
        queue_load(64'hFF, 1);
        queue_advance();
        queue_advance();
        queue_load(64'hFFFF, 2);
        queue_advance();
        queue_load(64'h0, 3);                         // longer than the limit
        wait_until_drained();

        // Random phases. Most loads are well formed, with bytes biased to the range ends
        // so that carries, growth and exhaustion come up often.
        for (int s = 1; s < NUM_SETS; s++) begin
            write_setting(s);
            send_idle_pct = SEND_IDLE[s];
            rcv_idle_pct  = RECV_IDLE[s];
            repeat (SET_ITEMS[s]) begin
                roll = $urandom_range(99);
                if (roll < 62) begin
                    queue_advance();
                end else begin
                    len = (roll < 95) ? $urandom_range(length_cap()) : $urandom_range(ID_BYTES);
                    word = {$urandom, $urandom};
                    if (roll < 90) begin
                        for (int i = 0; i < len; i++) begin
                            k = $urandom_range(1) ? active_ranges() - 1
                                                  : $urandom_range(active_ranges() - 1);
                            if (range_lo[k] <= range_hi[k]) begin
                                case ($urandom_range(3))
                                    0, 1:    ch = range_hi[k];
                                    2:       ch = range_lo[k];
                                    default: ch = range_lo[k]
                                                  + 8'($urandom_range(range_hi[k] - range_lo[k]));
                                endcase
                                word[8 * (len - 1 - i) +: 8] = ch;
                            end
                        end
                    end
                    queue_load(word, len);
                end
            end
            wait_until_drained();
        end

        // Let any stray response show up before the verdict.
        repeat (2 * ID_BYTES + 4) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
